[rtl/jlhd_pkg.sv]
// shared constants, code tables and result type for the luminance huffman symbol decoder
package jlhd_pkg;

   // field widths of one input beat and one result beat
   localparam int WindowWidth   = 32;
   localparam int IndexWidth    = 8;
   localparam int LengthWidth   = 5;
   localparam int NibbleWidth   = 4;
   localparam int CoefWidth     = 12;

   // longest ac code, which is also the bits of the window that take part in matching, and the count of ac values
   localparam int AcMaxLen      = 16;
   localparam int AcValueCount  = 162;

   // longest dc prefix and the widest amplitude field
   localparam int DcMaxLen      = 9;
   localparam int DcLongCount   = 6;
   localparam int DcLongFirstLen = 4;
   localparam int DcLongFirstCat = 6;
   localparam int AmpMaxBits    = 11;

   // action codes
   localparam logic ActionAc = 1'b0;
   localparam logic ActionDc = 1'b1;

   // canonical ac code: codes per length, first code and first table index of each length
   localparam logic [7:0] AcCount [AcMaxLen] = '{
      8'd0, 8'd2, 8'd1, 8'd3, 8'd3, 8'd2, 8'd4, 8'd3,
      8'd5, 8'd5, 8'd4, 8'd4, 8'd0, 8'd0, 8'd1, 8'd125
   };

   localparam logic [15:0] AcFirst [AcMaxLen] = '{
      16'd0,    16'd0,    16'd4,     16'd10,    16'd26,    16'd58,    16'd120,   16'd248,
      16'd502,  16'd1014, 16'd2038,  16'd4084,  16'd8176,  16'd16352, 16'd32704, 16'd65410
   };

   localparam logic [7:0] AcBase [AcMaxLen] = '{
      8'd0,  8'd0,  8'd2,  8'd3,  8'd6,  8'd9,  8'd11, 8'd15,
      8'd18, 8'd23, 8'd28, 8'd32, 8'd36, 8'd36, 8'd36, 8'd37
   };

   // dc prefixes for categories 6 to 11: ones then a closing zero
   localparam logic [8:0] DcLongCodes [DcLongCount] = '{
      9'h00E, 9'h01E, 9'h03E, 9'h07E, 9'h0FE, 9'h1FE
   };

   // run/size value of each canonical ac index
   localparam logic [7:0] RunSizeVals [AcValueCount] = '{
      8'h01, 8'h02, 8'h03, 8'h00, 8'h04, 8'h11, 8'h05, 8'h12, 8'h21, 8'h31, 8'h41, 8'h06,
      8'h13, 8'h51, 8'h61, 8'h07, 8'h22, 8'h71, 8'h14, 8'h32, 8'h81, 8'h91, 8'hA1, 8'h08,
      8'h23, 8'h42, 8'hB1, 8'hC1, 8'h15, 8'h52, 8'hD1, 8'hF0, 8'h24, 8'h33, 8'h62, 8'h72,
      8'h82, 8'h09, 8'h0A, 8'h16, 8'h17, 8'h18, 8'h19, 8'h1A, 8'h25, 8'h26, 8'h27, 8'h28,
      8'h29, 8'h2A, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h3A, 8'h43, 8'h44, 8'h45,
      8'h46, 8'h47, 8'h48, 8'h49, 8'h4A, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58, 8'h59,
      8'h5A, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6A, 8'h73, 8'h74, 8'h75,
      8'h76, 8'h77, 8'h78, 8'h79, 8'h7A, 8'h83, 8'h84, 8'h85, 8'h86, 8'h87, 8'h88, 8'h89,
      8'h8A, 8'h92, 8'h93, 8'h94, 8'h95, 8'h96, 8'h97, 8'h98, 8'h99, 8'h9A, 8'hA2, 8'hA3,
      8'hA4, 8'hA5, 8'hA6, 8'hA7, 8'hA8, 8'hA9, 8'hAA, 8'hB2, 8'hB3, 8'hB4, 8'hB5, 8'hB6,
      8'hB7, 8'hB8, 8'hB9, 8'hBA, 8'hC2, 8'hC3, 8'hC4, 8'hC5, 8'hC6, 8'hC7, 8'hC8, 8'hC9,
      8'hCA, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6, 8'hD7, 8'hD8, 8'hD9, 8'hDA, 8'hE1, 8'hE2,
      8'hE3, 8'hE4, 8'hE5, 8'hE6, 8'hE7, 8'hE8, 8'hE9, 8'hEA, 8'hF1, 8'hF2, 8'hF3, 8'hF4,
      8'hF5, 8'hF6, 8'hF7, 8'hF8, 8'hF9, 8'hFA
   };

   // one decoded symbol
   typedef struct packed {
      logic                          found;
      logic [IndexWidth-1:0]         symbol_index;
      logic [LengthWidth-1:0]        code_length;
      logic [NibbleWidth-1:0]        zero_run;
      logic [NibbleWidth-1:0]        amp_size;
      logic signed [CoefWidth-1:0]   coef_value;
      logic [LengthWidth-1:0]        bits_used;
   } symbol_type;

endpackage

[rtl/jlhd_symbol_decode.sv]
// code match, run/size lookup and amplitude sign extension for one bit window
module jlhd_symbol_decode
   import jlhd_pkg::*;
(
   input  logic [WindowWidth-1:0] window,
   input  logic                   action,
   output symbol_type             result
);

   logic [AcMaxLen-1:0]     ac_code;
   logic [AcMaxLen-1:0]     ac_offs;
   logic                    ac_found;
   logic [IndexWidth-1:0]   ac_idx;
   logic [LengthWidth-1:0]  ac_len;
   logic [7:0]              ac_rs;
   logic                    ac_ok;

   logic [2:0]              dc_top3;
   logic [DcMaxLen-1:0]     dc_top9;
   logic                    dc_found;
   logic [NibbleWidth-1:0]  dc_cat;
   logic [LengthWidth-1:0]  dc_len;

   logic                    sel_found;
   logic [IndexWidth-1:0]   sel_idx;
   logic [LengthWidth-1:0]  sel_len;
   logic [NibbleWidth-1:0]  sel_run;
   logic [NibbleWidth-1:0]  sel_size;

   logic [WindowWidth-1:0]  amp_shift;
   logic [AmpMaxBits-1:0]   amp_top;
   logic [AmpMaxBits-1:0]   amp_val;
   logic [AmpMaxBits-1:0]   amp_max;
   logic [CoefWidth-1:0]    coef;

   // ac canonical match, shortest matching length wins
   always_comb begin
      ac_found = 1'b0;
      ac_idx   = '0;
      ac_len   = '0;
      ac_code  = '0;
      ac_offs  = '0;
      for (int k = AcMaxLen; k >= 1; k--) begin
         ac_code = window[WindowWidth-1 -: AcMaxLen] >> (AcMaxLen - k);
         ac_offs = ac_code - AcFirst[k-1];
         if ((ac_code >= AcFirst[k-1]) && (ac_offs < {8'd0, AcCount[k-1]})) begin
            ac_found = 1'b1;
            ac_idx   = AcBase[k-1] + ac_offs[IndexWidth-1:0];
            ac_len   = LengthWidth'(k);
         end
      end
   end

   // run/size lookup for the matched ac index
   assign ac_ok = ac_found && (ac_idx < IndexWidth'(AcValueCount));
   assign ac_rs = ac_ok ? RunSizeVals[ac_idx] : 8'd0;

   // dc category prefix match
   assign dc_top3 = window[WindowWidth-1 -: 3];
   assign dc_top9 = window[WindowWidth-1 -: DcMaxLen];

   always_comb begin
      dc_found = 1'b0;
      dc_cat   = '0;
      dc_len   = '0;
      if (window[WindowWidth-1 -: 2] == 2'b00) begin
         dc_found = 1'b1;
         dc_cat   = '0;
         dc_len   = LengthWidth'(2);
      end else if ((dc_top3 >= 3'd2) && (dc_top3 <= 3'd6)) begin
         dc_found = 1'b1;
         dc_cat   = NibbleWidth'(dc_top3 - 3'd1);
         dc_len   = LengthWidth'(3);
      end else begin
         for (int i = 0; i < DcLongCount; i++) begin
            if ((dc_top9 >> (DcMaxLen - DcLongFirstLen - i)) == DcLongCodes[i]) begin
               dc_found = 1'b1;
               dc_cat   = NibbleWidth'(i + DcLongFirstCat);
               dc_len   = LengthWidth'(i + DcLongFirstLen);
            end
         end
      end
   end

   // pick the table that the action asks for
   always_comb begin
      if (action == ActionDc) begin
         sel_found = dc_found;
         sel_idx   = IndexWidth'(dc_cat);
         sel_len   = dc_len;
         sel_run   = '0;
         sel_size  = dc_cat;
      end else begin
         sel_found = ac_ok;
         sel_idx   = ac_idx;
         sel_len   = ac_len;
         sel_run   = ac_rs[7:4];
         sel_size  = ac_rs[3:0];
      end
   end

   // amplitude bits after the code, negative when the leading bit is zero
   assign amp_shift = window << sel_len;
   assign amp_top   = amp_shift[WindowWidth-1 -: AmpMaxBits];
   assign amp_val   = amp_top >> (NibbleWidth'(AmpMaxBits) - sel_size);
   assign amp_max   = (AmpMaxBits'(1) << sel_size) - AmpMaxBits'(1);

   always_comb begin
      if (sel_size == '0) begin
         coef = '0;
      end else if (amp_top[AmpMaxBits-1]) begin
         coef = {1'b0, amp_val};
      end else begin
         coef = {1'b0, amp_val} - {1'b0, amp_max};
      end
   end

   // no match clears every field
   always_comb begin
      if (sel_found) begin
         result.found        = 1'b1;
         result.symbol_index = sel_idx;
         result.code_length  = sel_len;
         result.zero_run     = sel_run;
         result.amp_size     = sel_size;
         result.coef_value   = coef;
         result.bits_used    = sel_len + LengthWidth'(sel_size);
      end else begin
         result = '0;
      end
   end

endmodule

[rtl/jpeg_luma_huffman_symbol_decode_top.sv]
// top level: input register, symbol decode and result register with valid/stall flow control
//
// Decodes one symbol of the standard JPEG luminance Huffman code (AC run/size or DC
// category) from a 32-bit window, first stream bit in bit 31, and sign-extends the
// amplitude bits that follow the code. A beat is taken on every cycle that req_stall
// is low; between a request beat and its result lie one register for the request
// and one for the result, with the whole decode between them. With rsp_stall
// low the block sustains one symbol per cycle. Results leave in request order, and a
// stalled result does not block the next request from entering the input register.
// There is no reset sweep: the code tables are constant logic.
module jpeg_luma_huffman_symbol_decode_top
   import jlhd_pkg::*;
(
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [WindowWidth-1:0]       req_bit_window,
   input  logic                         req_action,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic                         rsp_found,
   output logic [IndexWidth-1:0]        rsp_symbol_index,
   output logic [LengthWidth-1:0]       rsp_code_length,
   output logic [NibbleWidth-1:0]       rsp_zero_run,
   output logic [NibbleWidth-1:0]       rsp_amp_size,
   output logic signed [CoefWidth-1:0]  rsp_coef_value,
   output logic [LengthWidth-1:0]       rsp_bits_used
);

   logic                    in_valid_ff, in_valid_in;
   logic [WindowWidth-1:0]  in_window_ff;
   logic                    in_action_ff;
   logic                    out_valid_ff, out_valid_in;
   symbol_type              out_res_ff;
   symbol_type              dec_res;
   logic                    out_free;
   logic                    in_take;
   logic                    out_take;

   // flow control between the two registers
   assign out_free     = !out_valid_ff || !rsp_stall;
   assign req_stall    = in_valid_ff && !out_free;
   assign in_take      = req_valid && !req_stall;
   assign out_take     = in_valid_ff && out_free;
   assign in_valid_in  = req_stall ? 1'b1 : req_valid;
   assign out_valid_in = out_free ? in_valid_ff : 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // request beat capture
   always_ff @(posedge clock) begin
      if (in_take) begin
         in_window_ff <= req_bit_window;
         in_action_ff <= req_action;
      end
   end

   jlhd_symbol_decode u_decode (
      .window (in_window_ff),
      .action (in_action_ff),
      .result (dec_res)
   );

   // result beat capture
   always_ff @(posedge clock) begin
      if (out_take) begin
         out_res_ff <= dec_res;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_found        = out_res_ff.found;
   assign rsp_symbol_index = out_res_ff.symbol_index;
   assign rsp_code_length  = out_res_ff.code_length;
   assign rsp_zero_run     = out_res_ff.zero_run;
   assign rsp_amp_size     = out_res_ff.amp_size;
   assign rsp_coef_value   = out_res_ff.coef_value;
   assign rsp_bits_used    = out_res_ff.bits_used;

   // a full input register behind a stalled result must hold off the requester
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && rsp_stall) |-> req_stall)
      else $error("request taken while both registers are full");

   // an unmatched code leaves the index, code length, size, coefficient and bit count clear
   a_miss_clear: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_symbol_index == '0 && rsp_code_length == '0 &&
         rsp_amp_size == '0 && rsp_coef_value == '0 && rsp_bits_used == '0))
      else $error("missed code with non-zero fields");

   // a matched symbol has a real code length and consistent bit count
   a_hit_length: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found) |-> (rsp_code_length != '0 &&
         rsp_code_length <= LengthWidth'(AcMaxLen) &&
         rsp_bits_used == rsp_code_length + LengthWidth'(rsp_amp_size)))
      else $error("matched symbol with bad code length");

   // size zero gives a zero coefficient
   a_size_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_found && rsp_amp_size == '0) |-> (rsp_coef_value == '0))
      else $error("zero-size symbol with non-zero coefficient");

endmodule
